### sv/csup_pkg.sv
package csup_pkg;

	// default width of the millisecond time base
	localparam int TIME_WIDTH_DEF = 32;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 20;

	localparam int TEMP_W = 12;
	localparam int VOLT_W = 14;
	localparam int STAB_W = 20;
	localparam int BMSTO_W = 16;

	// register indexes on the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_TEMP_WARN   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TEMP_CRIT   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_VOLT_HIGH   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_VOLT_LOW    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_NORM_HIGH   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_NORM_LOW    = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_STAB_PERIOD = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_BMS_TIMEOUT = 3'd7;

	// register reset values
	localparam logic [TEMP_W-1:0]  RST_TEMP_WARN   = 12'd600;
	localparam logic [TEMP_W-1:0]  RST_TEMP_CRIT   = 12'd700;
	localparam logic [VOLT_W-1:0]  RST_VOLT_HIGH   = 14'd1000;
	localparam logic [VOLT_W-1:0]  RST_VOLT_LOW    = 14'd480;
	localparam logic [VOLT_W-1:0]  RST_NORM_HIGH   = 14'd950;
	localparam logic [VOLT_W-1:0]  RST_NORM_LOW    = 14'd500;
	localparam logic [STAB_W-1:0]  RST_STAB_PERIOD = 20'd10000;
	localparam logic [BMSTO_W-1:0] RST_BMS_TIMEOUT = 16'd5000;

	// critical tier releases 10.0 C below its limit
	localparam logic [TEMP_W:0] TEMP_HYST_TENTHS = 13'd100;
	// BMS safe flag sampling interval
	localparam int BMS_SAMPLE_MS = 100;

	typedef enum logic [1:0] {
		END_NONE  = 2'd0,
		END_ESTOP = 2'd1,
		END_OTHER = 2'd2
	} end_cause_t;

	typedef struct packed {
		logic [TEMP_W-1:0]  temp_warn;
		logic [TEMP_W-1:0]  temp_crit;
		logic [VOLT_W-1:0]  volt_high;
		logic [VOLT_W-1:0]  volt_low;
		logic [VOLT_W-1:0]  norm_high;
		logic [VOLT_W-1:0]  norm_low;
		logic [STAB_W-1:0]  stab_period;
		logic [BMSTO_W-1:0] bms_timeout;
	} cfg_t;

	// non-time part of a poll snapshot
	typedef struct packed {
		logic              estop_pressed;
		logic              session_active;
		logic              session_running;
		logic              bms_allows;
		logic [TEMP_W-1:0] temp_tenths;
		logic [VOLT_W-1:0] volt_tenths;
		logic              battery_present;
		logic              drive_enabled;
	} snap_t;

	typedef struct packed {
		logic       stop_charger;
		logic       end_session;
		end_cause_t end_cause;
		logic       estop_alert;
		logic       temp_warn_alert;
		logic       fault_locked;
		logic       warn_tier;
		logic       critical_tier;
		logic       volt_fault;
	} res_t;

endpackage

### sv/csup_cfg.sv
module csup_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [csup_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [csup_pkg::CFG_DATA_W-1:0]  cfg_data,
	output csup_pkg::cfg_t                   cfg
);

	csup_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_warn   <= csup_pkg::RST_TEMP_WARN;
			cfg_q.temp_crit   <= csup_pkg::RST_TEMP_CRIT;
			cfg_q.volt_high   <= csup_pkg::RST_VOLT_HIGH;
			cfg_q.volt_low    <= csup_pkg::RST_VOLT_LOW;
			cfg_q.norm_high   <= csup_pkg::RST_NORM_HIGH;
			cfg_q.norm_low    <= csup_pkg::RST_NORM_LOW;
			cfg_q.stab_period <= csup_pkg::RST_STAB_PERIOD;
			cfg_q.bms_timeout <= csup_pkg::RST_BMS_TIMEOUT;
		end else if (cfg_valid) begin
			case (cfg_index)
				csup_pkg::REG_TEMP_WARN: begin
					cfg_q.temp_warn <= cfg_data[csup_pkg::TEMP_W-1:0];
				end
				csup_pkg::REG_TEMP_CRIT: begin
					cfg_q.temp_crit <= cfg_data[csup_pkg::TEMP_W-1:0];
				end
				csup_pkg::REG_VOLT_HIGH: begin
					cfg_q.volt_high <= cfg_data[csup_pkg::VOLT_W-1:0];
				end
				csup_pkg::REG_VOLT_LOW: begin
					cfg_q.volt_low <= cfg_data[csup_pkg::VOLT_W-1:0];
				end
				csup_pkg::REG_NORM_HIGH: begin
					cfg_q.norm_high <= cfg_data[csup_pkg::VOLT_W-1:0];
				end
				csup_pkg::REG_NORM_LOW: begin
					cfg_q.norm_low <= cfg_data[csup_pkg::VOLT_W-1:0];
				end
				csup_pkg::REG_STAB_PERIOD: begin
					cfg_q.stab_period <= cfg_data[csup_pkg::STAB_W-1:0];
				end
				csup_pkg::REG_BMS_TIMEOUT: begin
					cfg_q.bms_timeout <= cfg_data[csup_pkg::BMSTO_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/csup_core.sv
module csup_core #(
	parameter int TIME_WIDTH = csup_pkg::TIME_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step_en,
	input  logic [TIME_WIDTH-1:0] now_ms,
	input  logic [TIME_WIDTH-1:0] bms_seen_ms,
	input  csup_pkg::snap_t       snap,
	input  csup_pkg::cfg_t        cfg,
	output csup_pkg::res_t        res
);

	// compare width wide enough for both the time base and the hold period
	localparam int DW = (TIME_WIDTH > csup_pkg::STAB_W) ? TIME_WIDTH : csup_pkg::STAB_W;

	logic                  estop_q, prev_safe_q, warn_q, crit_q, volt_q, lock_q;
	logic [TIME_WIDTH-1:0] check_time_q, lock_time_q;

	logic                  estop_n, prev_safe_n, warn_n, crit_n, volt_n, lock_n;
	logic [TIME_WIDTH-1:0] check_time_n, lock_time_n;

	logic [TIME_WIDTH-1:0] bms_age, sample_age, lock_age;
	logic                  bms_late, sample_due, lock_aged;

	logic signed [csup_pkg::TEMP_W-1:0] t, tw, tc;
	logic signed [csup_pkg::TEMP_W:0]   t_ext, crit_rel;
	logic                               v_over, v_under, v_norm;

	logic                 can_end, stop_req, end_req, ealert, talert, set_lock;
	csup_pkg::end_cause_t cause;

	assign bms_age    = now_ms - bms_seen_ms;
	assign sample_age = now_ms - check_time_q;
	assign lock_age   = now_ms - lock_time_q;
	assign bms_late   = DW'(bms_age) > DW'(cfg.bms_timeout);
	assign sample_due = sample_age >= TIME_WIDTH'(csup_pkg::BMS_SAMPLE_MS);
	assign lock_aged  = DW'(lock_age) >= DW'(cfg.stab_period);

	assign t        = snap.temp_tenths;
	assign tw       = cfg.temp_warn;
	assign tc       = cfg.temp_crit;
	assign t_ext    = {snap.temp_tenths[csup_pkg::TEMP_W-1], snap.temp_tenths};
	assign crit_rel = {cfg.temp_crit[csup_pkg::TEMP_W-1], cfg.temp_crit}
		- csup_pkg::TEMP_HYST_TENTHS;

	assign v_over  = snap.volt_tenths > cfg.volt_high;
	assign v_under = snap.volt_tenths < cfg.volt_low;
	assign v_norm  = (snap.volt_tenths >= cfg.norm_low) && (snap.volt_tenths <= cfg.norm_high);

	assign can_end = snap.session_active & snap.session_running;

	// one poll, checks taken in fixed order; the first end request names the cause
	always_comb begin
		stop_req     = 1'b0;
		end_req      = 1'b0;
		cause        = csup_pkg::END_NONE;
		ealert       = 1'b0;
		talert       = 1'b0;
		set_lock     = 1'b0;
		estop_n      = estop_q;
		prev_safe_n  = prev_safe_q;
		check_time_n = check_time_q;
		warn_n       = warn_q;
		crit_n       = crit_q;
		volt_n       = volt_q;
		lock_n       = lock_q;
		lock_time_n  = lock_time_q;

		// e-stop
		if (snap.estop_pressed && !estop_q) begin
			stop_req = 1'b1;
			set_lock = 1'b1;
			estop_n  = 1'b1;
			ealert   = 1'b1;
			if (can_end) begin
				end_req = 1'b1;
				cause   = csup_pkg::END_ESTOP;
			end
		end else if (!snap.estop_pressed && estop_q) begin
			estop_n = 1'b0;
		end

		// BMS silence
		if (snap.session_active && bms_late) begin
			stop_req = 1'b1;
			if (snap.session_running) begin
				set_lock = 1'b1;
				if (!end_req) begin
					end_req = 1'b1;
					cause   = csup_pkg::END_OTHER;
				end
			end
		end

		// BMS safe flag edge, sampled
		if (sample_due) begin
			if (snap.bms_allows != prev_safe_q) begin
				if (!snap.bms_allows && can_end) begin
					set_lock = 1'b1;
					if (!end_req) begin
						end_req = 1'b1;
						cause   = csup_pkg::END_ESTOP;
					end
				end
				prev_safe_n = snap.bms_allows;
			end
			check_time_n = now_ms;
		end

		// warning tier
		if (t > tw && t <= tc && !warn_q) begin
			talert = 1'b1;
			warn_n = 1'b1;
		end else if (t <= tw && warn_q) begin
			warn_n = 1'b0;
		end

		// critical tier, with hysteresis
		if (t > tc && !crit_q) begin
			stop_req = 1'b1;
			if (can_end) begin
				set_lock = 1'b1;
				if (!end_req) begin
					end_req = 1'b1;
					cause   = csup_pkg::END_ESTOP;
				end
			end
			crit_n = 1'b1;
		end else if (t_ext < crit_rel && crit_q) begin
			crit_n = 1'b0;
			warn_n = 1'b0;
		end

		// voltage; low voltage while idle is not a fault
		if (snap.volt_tenths != '0 && snap.battery_present) begin
			if ((v_over || v_under) && !volt_q) begin
				if (!(v_under && !snap.drive_enabled && !snap.session_active)) begin
					if (can_end) begin
						set_lock = 1'b1;
						if (!end_req) begin
							end_req = 1'b1;
							cause   = csup_pkg::END_ESTOP;
						end
					end
					volt_n = 1'b1;
				end
			end else if (v_norm && volt_q) begin
				volt_n = 1'b0;
			end
		end

		if (set_lock) begin
			lock_n      = 1'b1;
			lock_time_n = now_ms;
		end

		// release judged on the lock as it stood before this poll, applied last
		if (lock_q && lock_aged && !estop_n && snap.bms_allows && !v_under && t <= tc) begin
			lock_n = 1'b0;
		end
	end

	always_comb begin
		res.stop_charger    = stop_req;
		res.end_session     = end_req;
		res.end_cause       = end_req ? cause : csup_pkg::END_NONE;
		res.estop_alert     = ealert;
		res.temp_warn_alert = talert;
		res.fault_locked    = lock_n;
		res.warn_tier       = warn_n;
		res.critical_tier   = crit_n;
		res.volt_fault      = volt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			estop_q      <= 1'b0;
			prev_safe_q  <= 1'b1;
			check_time_q <= '0;
			warn_q       <= 1'b0;
			crit_q       <= 1'b0;
			volt_q       <= 1'b0;
			lock_q       <= 1'b0;
			lock_time_q  <= '0;
		end else if (step_en) begin
			estop_q      <= estop_n;
			prev_safe_q  <= prev_safe_n;
			check_time_q <= check_time_n;
			warn_q       <= warn_n;
			crit_q       <= crit_n;
			volt_q       <= volt_n;
			lock_q       <= lock_n;
			lock_time_q  <= lock_time_n;
		end
	end

`ifndef SYNTHESIS
	// a lock raised this poll carries this poll's time
	assert property (@(posedge clk) disable iff (!arst_n)
		step_en && set_lock |=> lock_time_q == $past(now_ms))
		else $error("lock time not taken from the poll that set the lock");

	// e-stop edge always stops and leaves the lock held
	assert property (@(posedge clk) disable iff (!arst_n)
		step_en && ealert |=> lock_q && estop_q)
		else $error("e-stop edge did not leave lock and latch set");

	// a free lock only comes up through a set
	assert property (@(posedge clk) disable iff (!arst_n)
		step_en && !lock_q && !set_lock |=> !lock_q)
		else $error("lock raised without a cause");
`endif

endmodule

### sv/charger_safety_supervisor.sv
// Charger safety supervisor. Each input word is one poll snapshot (time, e-stop
// level, transaction flags, BMS time stamp and safe flag, temperature, voltage,
// battery and drive flags); each yields exactly one result word carrying the
// charger stop, end-transaction request with its cause, the e-stop and
// temperature-warning pulses and the current lock, tier and voltage flags.
// One word is taken every clock cycle unless both stages are full and out_ready
// is low: the snapshot is registered, the whole check runs in one pass of
// compares against the state flags, and the result is registered, so a result
// is offered once its word has moved from the input register into the result
// register. The result register and the input register form a two-deep queue,
// so a new word is taken while a finished result still waits. The configuration
// registers (index 0..7 on cfg_index, value on cfg_data, always ready) should be
// written only while no word is in flight. Times wrap modulo 2^TIME_WIDTH.
module charger_safety_supervisor #(
	parameter int TIME_WIDTH = csup_pkg::TIME_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [TIME_WIDTH-1:0]            now_ms,
	input  logic                             estop_pressed,
	input  logic                             session_active,
	input  logic                             session_running,
	input  logic [TIME_WIDTH-1:0]            bms_seen_ms,
	input  logic                             bms_allows,
	input  logic signed [11:0]               temp_tenths,
	input  logic [13:0]                      volt_tenths,
	input  logic                             battery_present,
	input  logic                             drive_enabled,

	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             stop_charger,
	output logic                             end_session,
	output logic [1:0]                       end_cause,
	output logic                             estop_alert,
	output logic                             temp_warn_alert,
	output logic                             fault_locked,
	output logic                             warn_tier,
	output logic                             critical_tier,
	output logic                             volt_fault,

	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [csup_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [csup_pkg::CFG_DATA_W-1:0]  cfg_data
);

	csup_pkg::cfg_t  cfg;
	csup_pkg::snap_t snap_s1;
	csup_pkg::res_t  res, res_s2;

	logic [TIME_WIDTH-1:0] now_s1, seen_s1;
	logic                  valid_s1, valid_s2;
	logic                  adv_s2, step;

	// result stage takes a new word when empty or being drained
	assign adv_s2   = !valid_s2 || out_ready;
	assign step     = valid_s1 && adv_s2;
	assign in_ready = !valid_s1 || adv_s2;
	assign cfg_ready = 1'b1;

	csup_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			now_s1                  <= now_ms;
			seen_s1                 <= bms_seen_ms;
			snap_s1.estop_pressed   <= estop_pressed;
			snap_s1.session_active  <= session_active;
			snap_s1.session_running <= session_running;
			snap_s1.bms_allows      <= bms_allows;
			snap_s1.temp_tenths     <= temp_tenths;
			snap_s1.volt_tenths     <= volt_tenths;
			snap_s1.battery_present <= battery_present;
			snap_s1.drive_enabled   <= drive_enabled;
		end
	end

	// check logic; state advances when the word moves into the result stage
	csup_core #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (step),
		.now_ms      (now_s1),
		.bms_seen_ms (seen_s1),
		.snap        (snap_s1),
		.cfg         (cfg),
		.res         (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign out_valid       = valid_s2;
	assign stop_charger    = res_s2.stop_charger;
	assign end_session     = res_s2.end_session;
	assign end_cause       = res_s2.end_cause;
	assign estop_alert     = res_s2.estop_alert;
	assign temp_warn_alert = res_s2.temp_warn_alert;
	assign fault_locked    = res_s2.fault_locked;
	assign warn_tier       = res_s2.warn_tier;
	assign critical_tier   = res_s2.critical_tier;
	assign volt_fault      = res_s2.volt_fault;

`ifndef SYNTHESIS
	// input only stalls with both stages full and the output held off
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && !out_ready)
		else $error("input stalled without a full pipeline");

	// a cause is given exactly when an end is requested
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (end_session == (res_s2.end_cause != csup_pkg::END_NONE)))
		else $error("end cause inconsistent with end request");

	// e-stop pulse stops the charger, holds the lock and wins the end cause
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && estop_alert |-> stop_charger && fault_locked &&
			(!end_session || res_s2.end_cause == csup_pkg::END_ESTOP))
		else $error("e-stop result incomplete");

	// a word in the input stage reaches the result stage when it has room
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> valid_s2)
		else $error("word lost between stages");
`endif

endmodule
